// ===== src/qlpp_pkg.sv =====
package qlpp_pkg;

  // Default sizing of the table store
  localparam int NUM_TABLES_DEF     = 8;
  localparam int MAX_HITS_DEF       = 16;
  localparam int MAX_PRIOR_HITS_DEF = 16;
  localparam int MAX_DEVICES_DEF    = 4;
  localparam int Q_WIDTH_DEF        = 32;
  localparam int RAM_DEPTH_DEF      =
    NUM_TABLES_DEF * MAX_HITS_DEF * MAX_PRIOR_HITS_DEF * MAX_DEVICES_DEF * 2;

  // Fixed-point datapath: 64-bit saturating accumulator, Q0.16 fractions
  localparam int ACC_W  = 64;
  localparam int FRAC_W = 16;

  // Configuration port
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_EXPLORE  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_LEARN    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_DISCOUNT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_HITS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_PRIOR    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_DEVICES  = 3'd5;

  // Register reset values
  localparam logic [13:0] EXPLORE_RST  = 14'd100;
  localparam logic [15:0] LEARN_RST    = 16'd6554;
  localparam logic [15:0] DISCOUNT_RST = 16'd58982;
  localparam logic [4:0]  HITS_RST     = 5'd16;
  localparam logic [4:0]  PRIOR_RST    = 5'd16;
  localparam logic [2:0]  DEVICES_RST  = 3'd4;

  // Operation codes
  localparam logic OP_UPDATE = 1'b0;
  localparam logic OP_CHOOSE = 1'b1;

  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

  // Saturating 64-bit add
  function automatic logic signed [ACC_W-1:0] sat_add(input logic signed [ACC_W-1:0] a,
                                                      input logic signed [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {a[ACC_W-1], a} + {b[ACC_W-1], b};
    if (s[ACC_W] != s[ACC_W-1]) begin
      sat_add = s[ACC_W] ? ACC_MIN : ACC_MAX;
    end else begin
      sat_add = signed'(s[ACC_W-1:0]);
    end
  endfunction

endpackage

// ===== src/qlpp_ram.sv =====
module qlpp_ram
  import qlpp_pkg::*;
#(
  parameter int WIDTH = Q_WIDTH_DEF,
  parameter int DEPTH = RAM_DEPTH_DEF
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Single port, read-first, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/qlpp_fmul.sv =====
// floor(frac * x / 2^16): unsigned Q0.16 fraction times a signed 64-bit word,
// in two 32-bit halves on consecutive cycles.
module qlpp_fmul
  import qlpp_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic [FRAC_W-1:0]       frac_i,
  input  logic signed [ACC_W-1:0] x_i,
  output logic                    done_o,
  output logic signed [ACC_W-1:0] prod_o
);

  localparam int HALF = ACC_W / 2;
  localparam int PW   = ACC_W + FRAC_W;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI} phase_e;

  phase_e phase_q, phase_d;
  logic   done_q, done_d;

  logic [FRAC_W-1:0]       f_q;
  logic signed [ACC_W-1:0] x_q;
  logic signed [PW-1:0]    acc_q;

  logic [FRAC_W+HALF-1:0]      lo_prod;
  logic signed [FRAC_W+HALF:0] hi_prod;

  // Partial products: low half unsigned, high half carries the sign
  always_comb begin
    lo_prod = (FRAC_W+HALF)'(f_q) * (FRAC_W+HALF)'(x_q[HALF-1:0]);
    hi_prod = (FRAC_W+HALF+1)'($signed({1'b0, f_q}))
            * (FRAC_W+HALF+1)'($signed(x_q[ACC_W-1:HALF]));
  end

  // Sequencer
  always_comb begin
    phase_d = phase_q;
    done_d  = 1'b0;
    case (phase_q)
      PH_IDLE: if (start_i) phase_d = PH_LO;
      PH_LO:   phase_d = PH_HI;
      PH_HI: begin
        phase_d = PH_IDLE;
        done_d  = 1'b1;
      end
      default: phase_d = PH_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
    end else begin
      phase_q <= phase_d;
      done_q  <= done_d;
    end
  end

  // Operands and accumulator
  always_ff @(posedge clk_i) begin
    if (phase_q == PH_IDLE && start_i) begin
      f_q <= frac_i;
      x_q <= x_i;
    end
    if (phase_q == PH_LO) begin
      acc_q <= signed'(PW'(lo_prod));
    end else if (phase_q == PH_HI) begin
      acc_q <= acc_q + (PW'(hi_prod) <<< HALF);
    end
  end

  assign done_o = done_q;
  assign prod_o = acc_q[PW-1:FRAC_W];

endmodule

// ===== src/q_learning_page_placement.sv =====
// Q-learning page placement engine. Q tables sit in one single-port RAM of
// NUM_TABLES*MAX_HITS*MAX_PRIOR_HITS*MAX_DEVICES*2 words. After reset the RAM
// is swept to zero, one word per cycle, with busy_o high. An item is taken
// when start_i is high and busy_o low; its result shows for one cycle with
// done_o and cannot be held off. A choose holds busy_o high through the
// offset, address and read states; the two reads go through the one RAM port.
// An update adds the two fraction multiplies, each in two 32-bit halves; an
// item with a range error drops busy_o after the offset state.
// Items are worked one at a time, so an update's write lands before the next
// item reads. A configuration write holds busy_o high while the table strides
// settle; cfg_ready_o is always high.
module q_learning_page_placement
  import qlpp_pkg::*;
#(
  parameter int NUM_TABLES     = NUM_TABLES_DEF,
  parameter int MAX_HITS       = MAX_HITS_DEF,
  parameter int MAX_PRIOR_HITS = MAX_PRIOR_HITS_DEF,
  parameter int MAX_DEVICES    = MAX_DEVICES_DEF,
  parameter int Q_WIDTH        = Q_WIDTH_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  output logic                  busy_o,
  input  logic                  operation_i,
  input  logic [2:0]            table_index_i,
  input  logic [3:0]            hits_i,
  input  logic [3:0]            prior_hits_i,
  input  logic [1:0]            current_device_i,
  input  logic                  chosen_device_i,
  input  logic [3:0]            next_hits_i,
  input  logic [3:0]            next_prior_hits_i,
  input  logic [1:0]            next_device_i,
  input  logic                  next_chosen_device_i,
  input  logic signed [31:0]    reward_i,
  input  logic [13:0]           random_draw_i,
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output logic                  done_o,
  output logic                  action_o,
  output logic signed [31:0]    q_value_o,
  output logic                  range_error_o
);

  localparam int TABLE_SIZE = MAX_HITS * MAX_PRIOR_HITS * MAX_DEVICES * 2;
  localparam int DEPTH      = NUM_TABLES * TABLE_SIZE;
  localparam int AW         = $clog2(DEPTH);
  localparam int OW         = $clog2(TABLE_SIZE);
  localparam int MW         = OW + 4;
  localparam int HW         = $clog2(MAX_HITS + 1);
  localparam int PW         = $clog2(MAX_PRIOR_HITS + 1);
  localparam int DW         = $clog2(MAX_DEVICES + 1);

  localparam logic signed [ACC_W-1:0] QMAX =
    signed'((ACC_W'(1) << (Q_WIDTH - 1)) - ACC_W'(1));
  localparam logic signed [ACC_W-1:0] QMIN = ~QMAX;

  typedef enum logic [3:0] {
    ST_IDLE, ST_OFS, ST_ADDR, ST_RD0, ST_RD1, ST_RDW, ST_MULD, ST_SUM, ST_MULL
  } state_e;

  // ---------------------------------------------------------------------------
  // Configuration registers
  logic [13:0] thr_q;
  logic [15:0] lr_q, df_q;
  logic [4:0]  hsz_q, psz_q;
  logic [2:0]  dsz_q;
  logic [1:0]  settle_q;
  logic        cfg_wr;

  assign cfg_ready_o = 1'b1;
  assign cfg_wr      = cfg_valid_i & cfg_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= EXPLORE_RST;
      lr_q     <= LEARN_RST;
      df_q     <= DISCOUNT_RST;
      hsz_q    <= HITS_RST;
      psz_q    <= PRIOR_RST;
      dsz_q    <= DEVICES_RST;
      settle_q <= 2'd2;
    end else begin
      if (cfg_wr) begin
        settle_q <= 2'd2;
        case (cfg_index_i)
          CFG_EXPLORE:  thr_q <= cfg_data_i[13:0];
          CFG_LEARN:    lr_q  <= cfg_data_i;
          CFG_DISCOUNT: df_q  <= cfg_data_i;
          CFG_HITS:     hsz_q <= cfg_data_i[4:0];
          CFG_PRIOR:    psz_q <= cfg_data_i[4:0];
          CFG_DEVICES:  dsz_q <= cfg_data_i[2:0];
          default: ;
        endcase
      end else if (settle_q != 2'd0) begin
        settle_q <= settle_q - 2'd1;
      end
    end
  end

  // Effective sizes, clamped to 1..max
  logic [HW-1:0] x0;
  logic [PW-1:0] x1;
  logic [DW-1:0] ysz;

  always_comb begin
    if (hsz_q == '0) x0 = HW'(1);
    else if (32'(hsz_q) > 32'(MAX_HITS)) x0 = HW'(MAX_HITS);
    else x0 = HW'(hsz_q);
    if (psz_q == '0) x1 = PW'(1);
    else if (32'(psz_q) > 32'(MAX_PRIOR_HITS)) x1 = PW'(MAX_PRIOR_HITS);
    else x1 = PW'(psz_q);
    if (dsz_q == '0) ysz = DW'(1);
    else if (32'(dsz_q) > 32'(MAX_DEVICES)) ysz = DW'(MAX_DEVICES);
    else ysz = DW'(dsz_q);
  end

  // Table strides: X0*X1 and X0*X1*Y, one multiply per register
  logic [MW-1:0] s2_q, s3_q;

  always_ff @(posedge clk_i) begin
    s2_q <= MW'(x0) * MW'(x1);
    s3_q <= s2_q * MW'(ysz);
  end

  // ---------------------------------------------------------------------------
  // Clearing sweep after reset
  logic          clr_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      clr_addr_q <= clr_addr_q + AW'(1);
      if (clr_addr_q == AW'(DEPTH - 1)) clr_q <= 1'b0;
    end
  end

  // ---------------------------------------------------------------------------
  state_e state_q, state_d;
  logic   accept;

  assign busy_o = clr_q | (settle_q != 2'd0) | (state_q != ST_IDLE);
  assign accept = start_i & ~busy_o;

  // Latched item
  logic               op_q, a_q, na_q;
  logic [2:0]         tbl_q;
  logic [3:0]         h_q, p_q, nh_q, np_q;
  logic [1:0]         d_q, nd_q;
  logic signed [31:0] rew_q;
  logic [13:0]        draw_q;

  // State A is the entry written or device 0; state B the next state or device 1
  logic [3:0] ha, pa, hb, pb;
  logic [1:0] da, db;
  logic       ta, tb, err;

  always_comb begin
    ha = h_q;
    pa = p_q;
    da = d_q;
    ta = (op_q == OP_UPDATE) ? a_q : 1'b0;
    if (op_q == OP_UPDATE) begin
      hb = nh_q;
      pb = np_q;
      db = nd_q;
      tb = na_q;
    end else begin
      hb = h_q;
      pb = p_q;
      db = d_q;
      tb = 1'b1;
    end
    err = (32'(tbl_q) >= 32'(NUM_TABLES))
        | (MW'(ha) >= MW'(x0)) | (MW'(pa) >= MW'(x1)) | (MW'(da) >= MW'(ysz))
        | (MW'(hb) >= MW'(x0)) | (MW'(pb) >= MW'(x1)) | (MW'(db) >= MW'(ysz));
  end

  // Offset terms and addresses
  logic [MW-1:0] pa_q, da_q, pb_q, db_q;
  logic          ta_q, tb_q;
  logic [AW-1:0] base_q, addr_a_q, addr_b_q;
  logic [MW-1:0] off_a, off_b;

  always_comb begin
    off_a = pa_q + da_q + (ta_q ? s3_q : '0);
    off_b = pb_q + db_q + (tb_q ? s3_q : '0);
  end

  // ---------------------------------------------------------------------------
  // Table RAM
  logic [Q_WIDTH-1:0] rdata, wdata;
  logic [AW-1:0]      mem_addr;
  logic               mem_we, upd_we;

  assign mem_addr = clr_q ? clr_addr_q : ((state_q == ST_RD1) ? addr_b_q : addr_a_q);
  assign mem_we   = clr_q | upd_we;

  qlpp_ram #(
    .WIDTH(Q_WIDTH),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .addr_i (mem_addr),
    .wdata_i(wdata),
    .rdata_o(rdata)
  );

  // ---------------------------------------------------------------------------
  // Arithmetic
  logic signed [Q_WIDTH-1:0] q_a_q, rd_s;
  logic signed [ACC_W-1:0]   qa64, rd64, rew64, negq, t_q, negq_q, t2, nv_raw, nv;
  logic                      mul_start, mul_done;
  logic [FRAC_W-1:0]         mul_frac;
  logic signed [ACC_W-1:0]   mul_x, mul_prod;

  always_comb begin
    rd_s  = signed'(rdata);
    rd64  = ACC_W'(rd_s);
    qa64  = ACC_W'(q_a_q);
    rew64 = ACC_W'(rew_q) <<< FRAC_W;
    negq  = (qa64 == ACC_MIN) ? ACC_MAX : -qa64;
    t2    = sat_add(t_q, negq_q);
    nv_raw = sat_add(qa64, mul_prod);
    if (nv_raw > QMAX) nv = QMAX;
    else if (nv_raw < QMIN) nv = QMIN;
    else nv = nv_raw;
    wdata = clr_q ? '0 : Q_WIDTH'(nv);
  end

  assign mul_frac = (state_q == ST_SUM) ? lr_q : df_q;
  assign mul_x    = (state_q == ST_SUM) ? t2 : rd64;

  qlpp_fmul u_fmul (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(mul_start),
    .frac_i (mul_frac),
    .x_i    (mul_x),
    .done_o (mul_done),
    .prod_o (mul_prod)
  );

  // Choose decision
  logic choose_act;

  always_comb begin
    if (draw_q >= thr_q) choose_act = (q_a_q > rd_s) ? 1'b0 : 1'b1;
    else choose_act = draw_q[0] ? 1'b0 : 1'b1;
  end

  // ---------------------------------------------------------------------------
  // Sequencer
  logic               done_q, done_d, action_q, action_d, err_q, err_d;
  logic signed [31:0] qval_q, qval_d;

  always_comb begin
    state_d   = state_q;
    done_d    = 1'b0;
    action_d  = action_q;
    qval_d    = qval_q;
    err_d     = err_q;
    mul_start = 1'b0;
    upd_we    = 1'b0;
    case (state_q)
      ST_IDLE: if (accept) state_d = ST_OFS;
      ST_OFS: begin
        if (err) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          action_d = 1'b0;
          qval_d   = '0;
          err_d    = 1'b1;
        end else begin
          state_d = ST_ADDR;
        end
      end
      ST_ADDR: state_d = ST_RD0;
      ST_RD0:  state_d = ST_RD1;
      ST_RD1:  state_d = ST_RDW;
      ST_RDW: begin
        if (op_q == OP_CHOOSE) begin
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          action_d = choose_act;
          qval_d   = choose_act ? 32'(rd_s) : 32'(q_a_q);
          err_d    = 1'b0;
        end else begin
          mul_start = 1'b1;
          state_d   = ST_MULD;
        end
      end
      ST_MULD: if (mul_done) state_d = ST_SUM;
      ST_SUM: begin
        mul_start = 1'b1;
        state_d   = ST_MULL;
      end
      ST_MULL: begin
        if (mul_done) begin
          upd_we   = 1'b1;
          state_d  = ST_IDLE;
          done_d   = 1'b1;
          action_d = 1'b0;
          qval_d   = nv[31:0];
          err_d    = 1'b0;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      done_q   <= 1'b0;
      action_q <= 1'b0;
      qval_q   <= '0;
      err_q    <= 1'b0;
    end else begin
      state_q  <= state_d;
      done_q   <= done_d;
      action_q <= action_d;
      qval_q   <= qval_d;
      err_q    <= err_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= operation_i;
      tbl_q  <= table_index_i;
      h_q    <= hits_i;
      p_q    <= prior_hits_i;
      d_q    <= current_device_i;
      a_q    <= chosen_device_i;
      nh_q   <= next_hits_i;
      np_q   <= next_prior_hits_i;
      nd_q   <= next_device_i;
      na_q   <= next_chosen_device_i;
      rew_q  <= reward_i;
      draw_q <= random_draw_i;
    end
    if (state_q == ST_OFS) begin
      pa_q   <= MW'(ha) + MW'(pa) * MW'(x0);
      da_q   <= MW'(da) * s2_q;
      ta_q   <= ta;
      pb_q   <= MW'(hb) + MW'(pb) * MW'(x0);
      db_q   <= MW'(db) * s2_q;
      tb_q   <= tb;
      base_q <= AW'(tbl_q) * AW'(TABLE_SIZE);
    end
    if (state_q == ST_ADDR) begin
      addr_a_q <= base_q + AW'(off_a[OW-1:0]);
      addr_b_q <= base_q + AW'(off_b[OW-1:0]);
    end
    if (state_q == ST_RD1) begin
      q_a_q <= rd_s;
    end
    if (state_q == ST_MULD && mul_done) begin
      t_q    <= sat_add(rew64, mul_prod);
      negq_q <= negq;
    end
  end

  assign done_o        = done_q;
  assign action_o      = action_q;
  assign q_value_o     = qval_q;
  assign range_error_o = err_q;

endmodule

// ===== verif/q_learning_page_placement_checker.sv =====
module q_learning_page_placement_checker
  import qlpp_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start_i,
  input  logic                  busy_i,
  input  logic                  operation_i,
  input  logic [2:0]            table_index_i,
  input  logic [3:0]            hits_i,
  input  logic [3:0]            prior_hits_i,
  input  logic [1:0]            current_device_i,
  input  logic                  chosen_device_i,
  input  logic [3:0]            next_hits_i,
  input  logic [3:0]            next_prior_hits_i,
  input  logic [1:0]            next_device_i,
  input  logic                  next_chosen_device_i,
  input  logic signed [31:0]    reward_i,
  input  logic [13:0]           random_draw_i,
  input  logic                  cfg_valid_i,
  input  logic                  cfg_ready_i,
  input  logic [CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  input  logic                  done_i,
  input  logic                  action_i,
  input  logic signed [31:0]    q_value_i,
  input  logic                  range_error_i,
  output int                    fail_count_o,
  output int                    pending_o
);

  localparam int TABLE_WORDS = MAX_HITS_DEF * MAX_PRIOR_HITS_DEF * MAX_DEVICES_DEF * 2;
  localparam logic signed [ACC_W-1:0] Q_MAX = 64'sd2147483647;
  localparam logic signed [ACC_W-1:0] Q_MIN = -64'sd2147483648;

  typedef struct packed {
    logic               action;
    logic signed [31:0] q_value;
    logic               range_error;
  } placement_result_t;

  // Shadow of the Q tables and the register file
  placement_result_t  q_results_due[$];
  logic signed [31:0] q_mem [RAM_DEPTH_DEF];
  logic [13:0]        explore_thr;
  logic [15:0]        learn_rate;
  logic [15:0]        discount;
  logic [4:0]         hits_sz;
  logic [4:0]         prior_sz;
  logic [2:0]         dev_sz;
  int                 fails;

  function automatic int active_size(input int raw, input int limit);
    if (raw < 1) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  // Word address of a state/target pair; -1 when a field is past its active size
  function automatic int entry_addr(input logic [2:0] tbl, input logic [3:0] h,
                                    input logic [3:0] p, input logic [1:0] d,
                                    input logic tgt);
    int x0, x1, y;
    x0 = active_size(int'(hits_sz), MAX_HITS_DEF);
    x1 = active_size(int'(prior_sz), MAX_PRIOR_HITS_DEF);
    y  = active_size(int'(dev_sz), MAX_DEVICES_DEF);
    if (int'(tbl) >= NUM_TABLES_DEF || int'(h) >= x0 || int'(p) >= x1 || int'(d) >= y)
      return -1;
    return int'(tbl) * TABLE_WORDS + int'(h) + int'(p) * x0 + int'(d) * x0 * x1
           + int'(tgt) * x0 * x1 * y;
  endfunction

  // floor(frac * x / 2**16), exact
  function automatic logic signed [ACC_W-1:0] frac_scale(input logic [15:0] frac,
                                                          input logic signed [ACC_W-1:0] x);
    logic signed [ACC_W+16:0] prod;
    prod = (ACC_W+17)'($signed({1'b0, frac})) * (ACC_W+17)'(x);
    prod = prod >>> FRAC_W;
    return prod[ACC_W-1:0];
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    placement_result_t       want, got;
    int                      a0, a1;
    logic signed [ACC_W-1:0] q_cur, q_nxt, reward_fx, delta, q_new;
    logic signed [31:0]      m0, m1;
    if (!rst_ni) begin
      foreach (q_mem[i]) q_mem[i] = '0;
      explore_thr = EXPLORE_RST;
      learn_rate  = LEARN_RST;
      discount    = DISCOUNT_RST;
      hits_sz     = HITS_RST;
      prior_sz    = PRIOR_RST;
      dev_sz      = DEVICES_RST;
      q_results_due.delete();
      fails = 0;
    end else begin
      // finished word against the oldest prediction
      if (done_i) begin
        got = '{action_i, q_value_i, range_error_i};
        if (q_results_due.size() == 0) begin
          $error("unexpected result: action %0d q_value %0d range_error %0d",
                 got.action, got.q_value, got.range_error);
          fails++;
        end else begin
          want = q_results_due.pop_front();
          if (got.action !== want.action) begin
            $error("action: expected %0d, got %0d", want.action, got.action);
            fails++;
          end
          if (got.q_value !== want.q_value) begin
            $error("q_value: expected %0d, got %0d", want.q_value, got.q_value);
            fails++;
          end
          if (got.range_error !== want.range_error) begin
            $error("range_error: expected %0d, got %0d", want.range_error, got.range_error);
            fails++;
          end
        end
      end

      // register writes; unknown indexes fall through
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          CFG_EXPLORE:  explore_thr = cfg_data_i[13:0];
          CFG_LEARN:    learn_rate  = cfg_data_i;
          CFG_DISCOUNT: discount    = cfg_data_i;
          CFG_HITS:     hits_sz     = cfg_data_i[4:0];
          CFG_PRIOR:    prior_sz    = cfg_data_i[4:0];
          CFG_DEVICES:  dev_sz      = cfg_data_i[2:0];
          default: ;
        endcase
      end

      // predict the word taken at this edge
      if (start_i && busy_i === 1'b0) begin
        want = '{1'b0, 32'sd0, 1'b1};
        if (operation_i == OP_UPDATE) begin
          a0 = entry_addr(table_index_i, hits_i, prior_hits_i, current_device_i,
                          chosen_device_i);
          a1 = entry_addr(table_index_i, next_hits_i, next_prior_hits_i, next_device_i,
                          next_chosen_device_i);
          if (a0 >= 0 && a1 >= 0) begin
            q_cur = ACC_W'(q_mem[a0]);
            q_nxt = ACC_W'(q_mem[a1]);
            reward_fx = ACC_W'(reward_i);
            reward_fx = reward_fx <<< FRAC_W;
            // magnitudes stay under 2**49 here, so the 64-bit sums never wrap
            delta = reward_fx + frac_scale(discount, q_nxt) - q_cur;
            q_new = q_cur + frac_scale(learn_rate, delta);
            if (q_new > Q_MAX) q_new = Q_MAX;
            else if (q_new < Q_MIN) q_new = Q_MIN;
            q_mem[a0] = q_new[31:0];
            want = '{1'b0, q_new[31:0], 1'b0};
          end
        end else begin
          a0 = entry_addr(table_index_i, hits_i, prior_hits_i, current_device_i, 1'b0);
          a1 = entry_addr(table_index_i, hits_i, prior_hits_i, current_device_i, 1'b1);
          if (a0 >= 0 && a1 >= 0) begin
            m0 = q_mem[a0];
            m1 = q_mem[a1];
            // greedy unless the draw falls under epsilon; then odd draws go to device 0
            if (random_draw_i >= explore_thr) want.action = (m0 > m1) ? 1'b0 : 1'b1;
            else want.action = random_draw_i[0] ? 1'b0 : 1'b1;
            want.q_value     = want.action ? m1 : m0;
            want.range_error = 1'b0;
          end
        end
        q_results_due.push_back(want);
      end
    end
    fail_count_o <= fails;
    pending_o    <= q_results_due.size();
  end

endmodule

// ===== verif/tb_q_learning_page_placement.sv =====
module tb_q_learning_page_placement;
  import qlpp_pkg::*;

  localparam int ITEMS_PER_SETUP = 292;
  localparam int WATCHDOG_LIMIT  = 60000;
  localparam int DRAIN_CYCLES    = 24;

  // indexes past the register list
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

  localparam logic signed [31:0] REWARD_MAX = 32'sh7FFFFFFF;
  localparam logic signed [31:0] REWARD_MIN = 32'sh80000000;

  typedef struct packed {
    logic               op;
    logic [2:0]         tbl;
    logic [3:0]         hits;
    logic [3:0]         prior;
    logic [1:0]         dev;
    logic               chosen;
    logic [3:0]         nhits;
    logic [3:0]         nprior;
    logic [1:0]         ndev;
    logic               nchosen;
    logic signed [31:0] reward;
    logic [13:0]        draw;
  } placement_cmd_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  start_i;
  logic                  busy_o;
  logic                  operation_i;
  logic [2:0]            table_index_i;
  logic [3:0]            hits_i;
  logic [3:0]            prior_hits_i;
  logic [1:0]            current_device_i;
  logic                  chosen_device_i;
  logic [3:0]            next_hits_i;
  logic [3:0]            next_prior_hits_i;
  logic [1:0]            next_device_i;
  logic                  next_chosen_device_i;
  logic signed [31:0]    reward_i;
  logic [13:0]           random_draw_i;
  logic                  cfg_valid_i;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  logic                  done_o;
  logic                  action_o;
  logic signed [31:0]    q_value_o;
  logic                  range_error_o;
  int                    fail_count;
  int                    pending;

  // Stimulus view of the active configuration
  int             idle_pct;
  int             size_h;
  int             size_p;
  int             size_d;
  int             cur_thr;
  placement_cmd_t last_cmd;

  always #6 clk_i = ~clk_i;

  q_learning_page_placement DUT (
    .clk_i, .rst_ni, .start_i, .busy_o, .operation_i, .table_index_i, .hits_i,
    .prior_hits_i, .current_device_i, .chosen_device_i, .next_hits_i,
    .next_prior_hits_i, .next_device_i, .next_chosen_device_i, .reward_i,
    .random_draw_i, .cfg_valid_i, .cfg_ready_o, .cfg_index_i, .cfg_data_i,
    .done_o, .action_o, .q_value_o, .range_error_o
  );

  q_learning_page_placement_checker u_checker (
    .clk_i, .rst_ni, .start_i,
    .busy_i               (busy_o),
    .operation_i, .table_index_i, .hits_i, .prior_hits_i, .current_device_i,
    .chosen_device_i, .next_hits_i, .next_prior_hits_i, .next_device_i,
    .next_chosen_device_i, .reward_i, .random_draw_i, .cfg_valid_i,
    .cfg_ready_i          (cfg_ready_o),
    .cfg_index_i, .cfg_data_i,
    .done_i               (done_o),
    .action_i             (action_o),
    .q_value_i            (q_value_o),
    .range_error_i        (range_error_o),
    .fail_count_o         (fail_count),
    .pending_o            (pending)
  );

  function automatic int bounded(input int raw, input int limit);
    if (raw < 1) return 1;
    return (raw > limit) ? limit : raw;
  endfunction

  function automatic placement_cmd_t make_cmd(input logic op, input int tbl, h, p, d, a,
                                              input int nh, np, nd, na,
                                              input logic signed [31:0] reward,
                                              input int draw);
    placement_cmd_t c;
    c.op      = op;
    c.tbl     = 3'(tbl);
    c.hits    = 4'(h);
    c.prior   = 4'(p);
    c.dev     = 2'(d);
    c.chosen  = 1'(a);
    c.nhits   = 4'(nh);
    c.nprior  = 4'(np);
    c.ndev    = 2'(nd);
    c.nchosen = 1'(na);
    c.reward  = reward;
    c.draw    = 14'(draw);
    return c;
  endfunction

  // Mostly in-range states on a few hot entries, chained into trajectories
  function automatic placement_cmd_t random_cmd();
    placement_cmd_t c;
    int             lim, span_h, span_p;
    c      = '0;
    lim    = ($urandom_range(9) < 7) ? 3 : 16;
    span_h = (size_h < lim) ? size_h : lim;
    span_p = (size_p < lim) ? size_p : lim;
    c.op   = 1'($urandom_range(1));
    c.tbl  = ($urandom_range(3) == 0) ? 3'($urandom_range(7)) : last_cmd.tbl;
    if ($urandom_range(9) < 4) begin
      c.hits  = last_cmd.nhits;
      c.prior = last_cmd.nprior;
      c.dev   = last_cmd.ndev;
    end else begin
      c.hits  = 4'($urandom_range(span_h - 1));
      c.prior = 4'($urandom_range(span_p - 1));
      c.dev   = 2'($urandom_range(size_d - 1));
    end
    c.nhits   = 4'($urandom_range(span_h - 1));
    c.nprior  = 4'($urandom_range(span_p - 1));
    c.ndev    = 2'($urandom_range(size_d - 1));
    c.chosen  = 1'($urandom_range(1));
    c.nchosen = 1'($urandom_range(1));
    // now and then a state goes anywhere its width allows
    if ($urandom_range(11) == 0) {c.hits, c.prior, c.dev} = 10'($urandom);
    if ($urandom_range(11) == 0) {c.nhits, c.nprior, c.ndev} = 10'($urandom);
    case ($urandom_range(7))
      0:       c.reward = ($urandom_range(1) == 0) ? REWARD_MAX : REWARD_MIN;
      1, 2:    c.reward = $urandom;
      default: c.reward = int'($urandom_range(400)) - 200;
    endcase
    case ($urandom_range(9))
      0:       c.draw = 14'($urandom_range(16383));
      1, 2:    c.draw = 14'(cur_thr + int'($urandom_range(6)) - 3);
      default: c.draw = 14'($urandom_range(9999));
    endcase
    return c;
  endfunction

  // Present one word, hold it until taken, then drop start and maybe idle
  task automatic issue(input placement_cmd_t c);
    @(negedge clk_i);
    operation_i          <= c.op;
    table_index_i        <= c.tbl;
    hits_i               <= c.hits;
    prior_hits_i         <= c.prior;
    current_device_i     <= c.dev;
    chosen_device_i      <= c.chosen;
    next_hits_i          <= c.nhits;
    next_prior_hits_i    <= c.nprior;
    next_device_i        <= c.ndev;
    next_chosen_device_i <= c.nchosen;
    reward_i             <= c.reward;
    random_draw_i        <= c.draw;
    start_i              <= 1'b1;
    do @(posedge clk_i); while (busy_o !== 1'b0);
    last_cmd = c;
    @(negedge clk_i);
    start_i <= 1'b0;
    while ($urandom_range(99) < idle_pct) @(negedge clk_i);
  endtask

  // Register write on a drained, idle engine
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    do @(posedge clk_i); while (pending != 0 || busy_o !== 1'b0);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (cfg_ready_o !== 1'b1);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic setup(input int thr, lr, disc, h, p, d);
    write_reg(CFG_EXPLORE, 16'(thr));
    write_reg(CFG_LEARN, 16'(lr));
    write_reg(CFG_DISCOUNT, 16'(disc));
    write_reg(CFG_HITS, 16'(h));
    write_reg(CFG_PRIOR, 16'(p));
    write_reg(CFG_DEVICES, 16'(d));
    cur_thr = thr & 32'h3FFF;
    size_h  = bounded(h & 31, MAX_HITS_DEF);
    size_p  = bounded(p & 31, MAX_PRIOR_HITS_DEF);
    size_d  = bounded(d & 7, MAX_DEVICES_DEF);
  endtask

  // Sizes sometimes out of range, sometimes with junk above the field
  task automatic random_setup();
    int h, p, d, thr;
    h = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(31, 17))
                                 : $urandom_range(16, 1);
    p = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(31, 17))
                                 : $urandom_range(16, 1);
    d = ($urandom_range(4) == 0) ? (($urandom_range(1) == 0) ? 0 : $urandom_range(7, 5))
                                 : $urandom_range(4, 1);
    if ($urandom_range(3) == 0) h += $urandom_range(2047) << 5;
    if ($urandom_range(3) == 0) d += $urandom_range(8191) << 3;
    thr = ($urandom_range(3) == 0) ? $urandom_range(16383) : $urandom_range(1000);
    setup(thr, $urandom_range(65535), $urandom_range(65535), h, p, d);
  endtask

  // No progress on any channel for too long ends the run
  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk_i);
      if ((start_i && busy_o === 1'b0) || done_o === 1'b1 || (cfg_valid_i && cfg_ready_o))
        quiet = 0;
      else
        quiet++;
    end
    $display("Mismatches found");
    $finish;
  end

  initial begin
    int ph, k, n;
    rst_ni               <= 1'b0;
    start_i              <= 1'b0;
    operation_i          <= OP_UPDATE;
    table_index_i        <= '0;
    hits_i               <= '0;
    prior_hits_i         <= '0;
    current_device_i     <= '0;
    chosen_device_i      <= 1'b0;
    next_hits_i          <= '0;
    next_prior_hits_i    <= '0;
    next_device_i        <= '0;
    next_chosen_device_i <= 1'b0;
    reward_i             <= '0;
    random_draw_i        <= '0;
    cfg_valid_i          <= 1'b0;
    cfg_index_i          <= CFG_EXPLORE;
    cfg_data_i           <= '0;
    idle_pct = 0;
    cur_thr  = EXPLORE_RST;
    size_h   = MAX_HITS_DEF;
    size_p   = MAX_PRIOR_HITS_DEF;
    size_d   = MAX_DEVICES_DEF;
    last_cmd = '0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Reset configuration: ties, both exploration parities, oversized draw,
    // saturation both ways, update on the word just written
    issue(make_cmd(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9999));
    issue(make_cmd(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 1));
    issue(make_cmd(OP_CHOOSE, 0, 0, 0, 0, 0, 0, 0, 0, 0, 0, 16383));
    issue(make_cmd(OP_UPDATE, 7, 15, 15, 3, 1, 15, 15, 3, 1, REWARD_MAX, 0));
    issue(make_cmd(OP_UPDATE, 7, 15, 15, 3, 1, 15, 15, 3, 1, 0, 16383));
    issue(make_cmd(OP_CHOOSE, 7, 15, 15, 3, 0, 0, 0, 0, 0, 0, 9999));
    issue(make_cmd(OP_UPDATE, 7, 0, 0, 0, 0, 15, 15, 3, 1, REWARD_MIN, 0));
    issue(make_cmd(OP_UPDATE, 7, 0, 0, 0, 0, 0, 0, 0, 0, -1, 0));
    issue(make_cmd(OP_UPDATE, 3, 5, 9, 2, 1, 5, 9, 2, 0, 1, 0));
    issue(make_cmd(OP_CHOOSE, 7, 0, 0, 0, 0, 0, 0, 0, 0, 0, 9999));

    // Full rates, sizes clamped from below and above, writes to spare indexes
    setup(0, 65535, 65535, 0, 31, 0);
    write_reg(CFG_SPARE_LO, 16'hFFFF);
    write_reg(CFG_SPARE_HI, 16'h1234);
    issue(make_cmd(OP_UPDATE, 1, 0, 15, 0, 1, 0, 3, 0, 0, REWARD_MAX, 0));
    issue(make_cmd(OP_UPDATE, 1, 1, 0, 0, 0, 0, 0, 0, 0, 5, 0));
    issue(make_cmd(OP_CHOOSE, 1, 0, 0, 1, 0, 0, 0, 0, 0, 0, 0));
    issue(make_cmd(OP_UPDATE, 1, 0, 0, 0, 0, 0, 0, 2, 0, 5, 0));
    issue(make_cmd(OP_CHOOSE, 1, 0, 15, 0, 1, 15, 15, 3, 1, 0, 0));
    issue(make_cmd(OP_UPDATE, 1, 0, 15, 0, 1, 0, 15, 0, 1, REWARD_MIN, 0));

    // Threshold above every sane draw, frozen learning, one prior bucket
    setup(16383, 0, 0, 16, 1, 7);
    issue(make_cmd(OP_CHOOSE, 2, 3, 0, 2, 0, 0, 0, 0, 0, 0, 16382));
    issue(make_cmd(OP_CHOOSE, 2, 3, 0, 2, 0, 0, 0, 0, 0, 0, 16383));
    issue(make_cmd(OP_UPDATE, 1, 0, 0, 0, 1, 0, 0, 0, 0, REWARD_MAX, 0));
    issue(make_cmd(OP_UPDATE, 1, 0, 1, 0, 0, 0, 0, 0, 0, 7, 0));
    issue(make_cmd(OP_CHOOSE, 4, 15, 0, 3, 0, 0, 0, 0, 0, 0, 9999));

    // Random traffic: sparse sender gaps, then dense gaps, then back to back.
    // Each setup change waits for the pipe to drain first.
    for (ph = 0; ph < 3; ph++) begin
      idle_pct = (ph == 0) ? 9 : (ph == 1) ? 71 : 0;
      for (k = 0; k < 2; k++) begin
        if (ph == 2 && k == 1) setup(10000, 65535, 65535, 16, 16, 4);
        else random_setup();
        for (n = 0; n < ITEMS_PER_SETUP; n++) issue(random_cmd());
      end
    end

    // drain, then give the engine time to show anything stray
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) $display("No mismatches found");
    else $display("Mismatches found");
    $finish;
  end

endmodule
